FILE: hdl/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared types and constants for the RIPv2 packet parser.
// ----------------------------------------------------------------------------
package rpp_pkg;

	// status codes of the end-of-packet word
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_COMMAND   = 4'd1;
	localparam logic [3:0] ST_VERSION   = 4'd2;
	localparam logic [3:0] ST_ZERO      = 4'd3;
	localparam logic [3:0] ST_FAMILY    = 4'd4;
	localparam logic [3:0] ST_TAG       = 4'd5;
	localparam logic [3:0] ST_MASK      = 4'd6;
	localparam logic [3:0] ST_METRIC    = 4'd7;
	localparam logic [3:0] ST_TRUNCATED = 4'd8;
	localparam logic [3:0] ST_TOO_MANY  = 4'd9;

	// result kinds
	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// RIP command values
	localparam logic [1:0] CMD_NONE     = 2'd0;
	localparam logic [1:0] CMD_REQUEST  = 2'd1;
	localparam logic [1:0] CMD_RESPONSE = 2'd2;

	// header layout
	localparam logic [7:0]  RIP_VERSION    = 8'd2;
	localparam logic [7:0]  OFFSET_RESET   = 8'd28;
	localparam logic [9:0]  POS_MAX        = 10'd1023;
	localparam logic [9:0]  HDR_LEN        = 10'd4;

	// byte index of the last byte of each field inside a 20-byte entry
	localparam logic [4:0] F_FAMILY_END = 5'd1;
	localparam logic [4:0] F_TAG_END    = 5'd3;
	localparam logic [4:0] F_ADDR_END   = 5'd7;
	localparam logic [4:0] F_MASK_END   = 5'd11;
	localparam logic [4:0] F_HOP_END    = 5'd15;
	localparam logic [4:0] F_METRIC_END = 5'd19;

	// result queue depth (room for two words per byte)
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic        kind;
		logic [4:0]  route_index;
		logic [31:0] route_addr;
		logic [31:0] route_mask;
		logic [31:0] next_hop;
		logic [4:0]  route_metric;
		logic [1:0]  command_code;
		logic [3:0]  status_code;
		logic [4:0]  entry_total;
		logic        last_result;
	} result_t;

	// words produced by one byte: count and up to two words, first in res0
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage

FILE: hdl/rpp_byte_parser.sv
// ----------------------------------------------------------------------------
// rpp_byte_parser
// Per-packet state and the per-byte checks; yields up to two result words.
// ----------------------------------------------------------------------------
module rpp_byte_parser #(
	parameter int MAX_ENTRIES = 25
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [7:0]          payload_offset,
	output rpp_pkg::push_t      push
);

	logic [9:0]  pos_q;
	logic [31:0] shift_q;
	logic [31:0] addr_q;
	logic [31:0] mask_q;
	logic [31:0] hop_q;
	logic [1:0]  cmd_q;
	logic [4:0]  count_q;
	logic [3:0]  err_q;

	logic [9:0]  pos_n;
	logic [31:0] shift_n;
	logic [31:0] addr_n;
	logic [31:0] mask_n;
	logic [31:0] hop_n;
	logic [1:0]  cmd_n;
	logic [4:0]  count_n;
	logic [3:0]  err_n;

	logic        in_payload;
	logic [9:0]  rel;
	logic [9:0]  ent_off;
	logic [17:0] quot_prod;
	logic [5:0]  quot;
	logic [9:0]  quot20;
	logic [9:0]  field_full;
	logic [4:0]  field;
	logic        in_entry;
	logic [15:0] want_family;
	logic [31:0] mask_inv;
	logic [31:0] mask_inv_p1;
	logic        emit;
	logic        truncated;
	rpp_pkg::result_t entry_res;
	rpp_pkg::result_t status_res;

	// position within the entry area: (rel - 4) mod 20 by reciprocal, exact below 1024
	always_comb begin
		in_payload = pos_q >= {2'b00, payload_offset};
		rel        = pos_q - {2'b00, payload_offset};
		ent_off    = rel - rpp_pkg::HDR_LEN;
		quot_prod  = 18'(ent_off) * 18'd205;
		quot       = quot_prod[17:12];
		quot20     = {quot, 4'b0000} + {2'b00, quot, 2'b00};
		field_full = ent_off - quot20;
		field      = field_full[4:0];
		in_entry   = in_payload && (rel >= rpp_pkg::HDR_LEN);
	end

	// checks and next state
	always_comb begin
		shift_n     = {shift_q[23:0], data_byte};
		addr_n      = addr_q;
		mask_n      = mask_q;
		hop_n       = hop_q;
		cmd_n       = cmd_q;
		count_n     = count_q;
		err_n       = err_q;
		emit        = 1'b0;
		want_family = (cmd_q == rpp_pkg::CMD_RESPONSE) ? 16'd2 : 16'd0;
		mask_inv    = ~shift_n;
		mask_inv_p1 = mask_inv + 32'd1;

		if (in_payload && rel == 10'd0) begin
			if (data_byte == 8'(rpp_pkg::CMD_REQUEST) ||
			    data_byte == 8'(rpp_pkg::CMD_RESPONSE)) begin
				cmd_n = data_byte[1:0];
			end else begin
				cmd_n = rpp_pkg::CMD_NONE;
				if (err_n == rpp_pkg::ST_OK) err_n = rpp_pkg::ST_COMMAND;
			end
		end else if (in_payload && rel == 10'd1) begin
			if (data_byte != rpp_pkg::RIP_VERSION && err_n == rpp_pkg::ST_OK)
				err_n = rpp_pkg::ST_VERSION;
		end else if (in_payload && !in_entry) begin
			if (data_byte != 8'd0 && err_n == rpp_pkg::ST_OK)
				err_n = rpp_pkg::ST_ZERO;
		end else if (in_entry) begin
			case (field)
				rpp_pkg::F_FAMILY_END: begin
					if (shift_n[15:0] != want_family && err_n == rpp_pkg::ST_OK)
						err_n = rpp_pkg::ST_FAMILY;
				end
				rpp_pkg::F_TAG_END: begin
					if (shift_n[15:0] != 16'd0 && err_n == rpp_pkg::ST_OK)
						err_n = rpp_pkg::ST_TAG;
				end
				rpp_pkg::F_ADDR_END: addr_n = shift_n;
				rpp_pkg::F_MASK_END: begin
					mask_n = shift_n;
					// ones then zeros: inverted mask must be of form 0..01..1
					if ((mask_inv & mask_inv_p1) != 32'd0 && err_n == rpp_pkg::ST_OK)
						err_n = rpp_pkg::ST_MASK;
				end
				rpp_pkg::F_HOP_END: hop_n = shift_n;
				rpp_pkg::F_METRIC_END: begin
					if ((shift_n < 32'd1 || shift_n > 32'd16) && err_n == rpp_pkg::ST_OK)
						err_n = rpp_pkg::ST_METRIC;
					if (err_n == rpp_pkg::ST_OK) begin
						if (count_q >= 5'(MAX_ENTRIES)) begin
							err_n = rpp_pkg::ST_TOO_MANY;
						end else begin
							emit    = 1'b1;
							count_n = count_q + 5'd1;
						end
					end
				end
				default: ;
			endcase
		end

		// end of packet
		truncated = !in_payload || rel < 10'd3 ||
		            (in_entry && field != rpp_pkg::F_METRIC_END);
		if (last_byte && truncated && err_n == rpp_pkg::ST_OK)
			err_n = rpp_pkg::ST_TRUNCATED;

		pos_n = (pos_q < rpp_pkg::POS_MAX) ? pos_q + 10'd1 : rpp_pkg::POS_MAX;
	end

	// result words
	always_comb begin
		entry_res              = '0;
		entry_res.kind         = rpp_pkg::KIND_ENTRY;
		entry_res.route_index  = count_q;
		entry_res.route_addr   = addr_q;
		entry_res.route_mask   = mask_q;
		entry_res.next_hop     = hop_q;
		entry_res.route_metric = shift_n[4:0];
		entry_res.command_code = cmd_q;
		entry_res.status_code  = rpp_pkg::ST_OK;
		entry_res.entry_total  = count_n;
		entry_res.last_result  = !last_byte;

		status_res              = '0;
		status_res.kind         = rpp_pkg::KIND_STATUS;
		status_res.command_code = cmd_n;
		status_res.status_code  = err_n;
		status_res.entry_total  = count_n;
		status_res.last_result  = 1'b1;

		push = '0;
		if (accept) begin
			if (emit && last_byte) begin
				push.count = 2'd2;
				push.res0  = entry_res;
				push.res1  = status_res;
			end else if (emit) begin
				push.count = 2'd1;
				push.res0  = entry_res;
			end else if (last_byte) begin
				push.count = 2'd1;
				push.res0  = status_res;
			end
		end
	end

	// packet state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			shift_q <= '0;
			addr_q  <= '0;
			mask_q  <= '0;
			hop_q   <= '0;
			cmd_q   <= rpp_pkg::CMD_NONE;
			count_q <= '0;
			err_q   <= rpp_pkg::ST_OK;
		end else if (accept) begin
			if (last_byte) begin
				pos_q   <= '0;
				shift_q <= '0;
				addr_q  <= '0;
				mask_q  <= '0;
				hop_q   <= '0;
				cmd_q   <= rpp_pkg::CMD_NONE;
				count_q <= '0;
				err_q   <= rpp_pkg::ST_OK;
			end else begin
				pos_q   <= pos_n;
				shift_q <= shift_n;
				addr_q  <= addr_n;
				mask_q  <= mask_n;
				hop_q   <= hop_n;
				cmd_q   <= cmd_n;
				count_q <= count_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

FILE: hdl/rpp_result_queue.sv
// ----------------------------------------------------------------------------
// rpp_result_queue
// Small result queue: takes up to two words a cycle while it has room, hands out one when out_ready is high.
// ----------------------------------------------------------------------------
module rpp_result_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  rpp_pkg::push_t     push,
	output logic               has_room,
	output logic               out_valid,
	input  logic               out_ready,
	output rpp_pkg::result_t   out_word
);

	rpp_pkg::result_t                   mem_q [rpp_pkg::QUEUE_DEPTH];
	logic [rpp_pkg::QUEUE_AW-1:0]       wr_ptr_q;
	logic [rpp_pkg::QUEUE_AW-1:0]       rd_ptr_q;
	logic [rpp_pkg::QUEUE_AW:0]         fill_q;
	logic [rpp_pkg::QUEUE_AW-1:0]       wr_ptr_p1;
	logic                               pop;

	// room for two words keeps the input side free of the output handshake
	assign has_room  = fill_q <= (rpp_pkg::QUEUE_AW+1)'(rpp_pkg::QUEUE_DEPTH - 2);
	assign out_valid = fill_q != '0;
	assign out_word  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	// storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.res0;
		if (push.count == 2'd2)
			mem_q[wr_ptr_p1] <= push.res1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (rpp_pkg::QUEUE_AW)'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (rpp_pkg::QUEUE_AW+1)'(push.count)
			          - (rpp_pkg::QUEUE_AW+1)'(pop);
		end
	end

endmodule

FILE: hdl/rip_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// rip_packet_parser_unit
// RIPv2 payload parser: one packet byte a word, emits route entries and status.
// ----------------------------------------------------------------------------
// A result word is written into the result queue when the byte that causes it
// is accepted and is offered behind any earlier words. Throughput: one byte a
// cycle; a byte giving two words offers them one after the other, and input
// stalls only while the 4-word result queue is short of two free slots. Reset
// (arst_n low) clears packet state and the queue and sets payload_offset to 28.
// ----------------------------------------------------------------------------
module rip_packet_parser_unit #(
	parameter int MAX_ENTRIES = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [4:0]  route_index,
	output logic [31:0] route_addr,
	output logic [31:0] route_mask,
	output logic [31:0] next_hop,
	output logic [4:0]  route_metric,
	output logic [1:0]  command_code,
	output logic [3:0]  status_code,
	output logic [4:0]  entry_total,
	output logic        last_result
);

	logic [7:0]       offset_q;
	logic             accept;
	logic             has_room;
	rpp_pkg::push_t   push;
	rpp_pkg::result_t word;

	assign cfg_ready = 1'b1;
	assign in_ready  = has_room;
	assign accept    = in_valid && has_room;

	// payload offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= rpp_pkg::OFFSET_RESET;
		end else if (cfg_valid) begin
			offset_q <= cfg_data;
		end
	end

	rpp_byte_parser #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.payload_offset (offset_q),
		.push           (push)
	);

	rpp_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.has_room  (has_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (word)
	);

	// result fields
	assign kind         = word.kind;
	assign route_index  = word.route_index;
	assign route_addr   = word.route_addr;
	assign route_mask   = word.route_mask;
	assign next_hop     = word.next_hop;
	assign route_metric = word.route_metric;
	assign command_code = word.command_code;
	assign status_code  = word.status_code;
	assign entry_total  = word.entry_total;
	assign last_result  = word.last_result;

endmodule
